>>> rtl/core/sgbr_pkg.sv
// ----------------------------------------------------------------------------
// sgbr_pkg
// types, glyph geometry and the 5x7 font table of the glyph block renderer
// ----------------------------------------------------------------------------
package sgbr_pkg;

  localparam int GLYPH_WIDTH  = 5;
  localparam int GLYPH_HEIGHT = 7;
  localparam int GLYPH_CELLS  = GLYPH_WIDTH * GLYPH_HEIGHT;

  typedef logic [GLYPH_CELLS-1:0] glyph_bits_t;
  typedef logic [2:0]             glyph_col_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic [5:0]  char_index;
    logic [8:0]  origin_x;
    logic [8:0]  origin_y;
    logic [15:0] color;
  } in_item_t;

  typedef struct packed {
    logic [10:0] block_x;
    logic [9:0]  block_y;
    logic [15:0] block_color;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [10:0] base_x;
    logic [9:0]  base_y;
    logic [15:0] color;
  } job_t;

  // row 0 in the top bits, leftmost column as the msb of each row
  function automatic glyph_bits_t font_bits(input logic [7:0] code);
    glyph_bits_t bits;
    case (code)
      8'h43:   bits = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      8'h44:   bits = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      8'h45:   bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      8'h49:   bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      8'h4D:   bits = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      8'h4F:   bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h50:   bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h54:   bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h30:   bits = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      8'h31:   bits = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h32:   bits = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      8'h33:   bits = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h34:   bits = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      8'h35:   bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      8'h36:   bits = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      8'h37:   bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38:   bits = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      8'h39:   bits = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
      8'h3A:   bits = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      default: bits = '0;
    endcase
    return bits;
  endfunction

endpackage

>>> rtl/core/scaled_glyph_block_renderer_unit.sv
// ----------------------------------------------------------------------------
// scaled_glyph_block_renderer_unit
// renders one character of a 5x7 font as square fill blocks of side SCALE
// ----------------------------------------------------------------------------
//  channel | dir | payload             | handshake
//  in_     | in  | sgbr_pkg::in_item_t  | in_valid / in_stall
//  out_    | out | sgbr_pkg::out_item_t | out_valid / out_stall
//
//  a character is scanned one font cell at a time, up to the last lit
//  cell (at most 35), by the cell walker; unknown codes emit no blocks
//  a font rom read stage ahead of the walker holds the next character, so
//  it is taken while the previous one is still being scanned
//  synchronous active-low reset clears the valid flags and the walker busy flag only
//  out_stall holds the output register and pauses the scan on a lit cell
// ----------------------------------------------------------------------------
module scaled_glyph_block_renderer_unit #(
  parameter int SCALE = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sgbr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sgbr_pkg::out_item_t out_data
);
  import sgbr_pkg::*;

  localparam int PITCH = (GLYPH_WIDTH + 1) * SCALE;

  logic        a_valid_r, a_valid_nxt;
  job_t        a_job_r;
  job_t        a_job_nxt;
  glyph_bits_t a_bits;
  logic        a_take;
  logic        in_xfer;
  logic [10:0] idx_off;

  assign in_stall = a_valid_r && !a_take;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    idx_off            = 11'(12'(in_data.char_index) * 12'(PITCH));
    a_job_nxt.base_x   = 11'(in_data.origin_x) + idx_off;
    a_job_nxt.base_y   = 10'(in_data.origin_y);
    a_job_nxt.color    = in_data.color;
    a_valid_nxt        = in_xfer || (a_valid_r && !a_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
    if (in_xfer) begin
      a_job_r <= a_job_nxt;
    end
  end

  sgbr_font_rom u_rom (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_code (in_data.char_code),
    .rd_bits (a_bits)
  );

  sgbr_cell_walker #(
    .SCALE (SCALE)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (a_valid_r),
    .job       (a_job_r),
    .job_bits  (a_bits),
    .job_take  (a_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/sgbr_font_rom.sv
// ----------------------------------------------------------------------------
// sgbr_font_rom
// synchronous font rom, one glyph bitmap per read, registered and held while rd_en is low
// ----------------------------------------------------------------------------
module sgbr_font_rom (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [7:0]           rd_code,
  output sgbr_pkg::glyph_bits_t rd_bits
);
  import sgbr_pkg::*;

  glyph_bits_t rd_bits_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_bits_r <= font_bits(rd_code);
    end
  end

  assign rd_bits = rd_bits_r;

endmodule

>>> rtl/core/sgbr_cell_walker.sv
// ----------------------------------------------------------------------------
// sgbr_cell_walker
// scans a glyph bitmap cell by cell and emits one block per lit cell
// ----------------------------------------------------------------------------
module sgbr_cell_walker #(
  parameter int SCALE = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  input  sgbr_pkg::job_t        job,
  input  sgbr_pkg::glyph_bits_t job_bits,
  output logic                  job_take,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sgbr_pkg::out_item_t   out_data
);
  import sgbr_pkg::*;

  localparam logic [10:0] STEP_X = 11'(SCALE);
  localparam logic [9:0]  STEP_Y = 10'(SCALE);
  localparam glyph_col_t  LAST_COL = glyph_col_t'(GLYPH_WIDTH - 1);

  logic        busy_r, busy_nxt;
  glyph_bits_t mask_r, mask_nxt;
  glyph_col_t  col_r, col_nxt;
  logic [10:0] x_r, x_nxt;
  logic [10:0] base_x_r, base_x_nxt;
  logic [9:0]  y_r, y_nxt;
  logic [15:0] color_r, color_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  glyph_bits_t shifted;
  logic        lit, out_free, step, done;

  assign shifted  = {mask_r[GLYPH_CELLS-2:0], 1'b0};
  assign lit      = mask_r[GLYPH_CELLS-1];
  assign out_free = !out_valid_r || !out_stall;
  assign step     = busy_r && (!lit || out_free);
  assign done     = step && (shifted == '0);
  assign job_take = job_valid && (!busy_r || done);

  always_comb begin
    busy_nxt      = busy_r;
    mask_nxt      = mask_r;
    col_nxt       = col_r;
    x_nxt         = x_r;
    base_x_nxt    = base_x_r;
    y_nxt         = y_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (step && lit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.block_x     = x_r;
      out_data_nxt.block_y     = y_r;
      out_data_nxt.block_color = color_r;
      out_data_nxt.last        = (mask_r[GLYPH_CELLS-2:0] == '0);
    end
    if (job_take) begin
      busy_nxt   = (job_bits != '0);
      mask_nxt   = job_bits;
      col_nxt    = '0;
      x_nxt      = job.base_x;
      base_x_nxt = job.base_x;
      y_nxt      = job.base_y;
      color_nxt  = job.color;
    end else if (step) begin
      busy_nxt = (shifted != '0);
      mask_nxt = shifted;
      if (col_r == LAST_COL) begin
        col_nxt = '0;
        x_nxt   = base_x_r;
        y_nxt   = y_r + STEP_Y;
      end else begin
        col_nxt = col_r + glyph_col_t'(1);
        x_nxt   = x_r + STEP_X;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mask_r     <= mask_nxt;
    col_r      <= col_nxt;
    x_r        <= x_nxt;
    base_x_r   <= base_x_nxt;
    y_r        <= y_nxt;
    color_r    <= color_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
